// ----- sv/sqb_pkg.sv -----
// Package for the sprite quad batcher: sizes, limits, state codes and the
// structs that travel between the slot cells, the control logic and the vertex emitter.
// Depends on nothing.
`timescale 1ns / 1ps

package sqb_pkg;

   // Sizing of the texture slot chain and the batch index counter
   localparam int TEXTURE_SLOTS = 32;
   localparam int MAX_QUADS     = 8192;
   localparam int TABLE_DEPTH   = 32;
   localparam int SLOT_LIMIT    = (TEXTURE_SLOTS > TABLE_DEPTH) ? TABLE_DEPTH :
                                  ((TEXTURE_SLOTS < 1) ? 1 : TEXTURE_SLOTS);
   localparam int COUNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int POS_W         = $clog2(TABLE_DEPTH);
   localparam int SLOT_W        = 6;
   localparam int INDEX_W       = 16;
   localparam int INDEX_STEP    = 6;
   localparam int INDEX_LIMIT   = MAX_QUADS * INDEX_STEP;
   localparam int WORD_W        = 32;
   localparam int CORNERS       = 4;
   localparam int CORNER_W      = 2;
   localparam int REQ_W         = 11 * WORD_W;
   localparam int RSP_W         = 184;
   localparam int RSP_PAD_W     = RSP_W - 5 * WORD_W - SLOT_W - INDEX_W;

   // Front-end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_RESOLVE
   } state_type;

   // One sprite as packed in req_tdata, first field in the lowest bits
   typedef struct packed {
      logic [WORD_W-1:0]        uv_corner3;
      logic [WORD_W-1:0]        uv_corner2;
      logic [WORD_W-1:0]        uv_corner1;
      logic [WORD_W-1:0]        uv_corner0;
      logic [WORD_W-1:0]        tex_id;
      logic [WORD_W-1:0]        rgba;
      logic signed [WORD_W-1:0] height;
      logic signed [WORD_W-1:0] width;
      logic signed [WORD_W-1:0] pos_z;
      logic signed [WORD_W-1:0] pos_y;
      logic signed [WORD_W-1:0] pos_x;
   } sprite_type;

   // One vertex as packed in rsp_tdata, first field in the lowest bits
   typedef struct packed {
      logic [RSP_PAD_W-1:0]     pad;
      logic [INDEX_W-1:0]       flushed_indices;
      logic [SLOT_W-1:0]        slot;
      logic [WORD_W-1:0]        vert_uv;
      logic [WORD_W-1:0]        vert_color;
      logic signed [WORD_W-1:0] vert_z;
      logic signed [WORD_W-1:0] vert_y;
      logic signed [WORD_W-1:0] vert_x;
   } vertex_type;

   // Control broadcast to every slot cell
   typedef struct packed {
      logic               shift;
      logic               look;
      logic [COUNT_W-1:0] count;
      logic [WORD_W-1:0]  query;
   } cell_ctrl_type;

   // Resolved quad handed to the emitter
   typedef struct packed {
      logic [SLOT_W-1:0]                slot;
      logic                             flush;
      logic [INDEX_W-1:0]               flushed;
      logic [WORD_W-1:0]                x0;
      logic [WORD_W-1:0]                x1;
      logic [WORD_W-1:0]                y0;
      logic [WORD_W-1:0]                y1;
      logic [WORD_W-1:0]                z;
      logic [WORD_W-1:0]                color;
      logic [CORNERS-1:0][WORD_W-1:0]   uv;
   } quad_type;

endpackage

// ----- sv/sqb_cell.sv -----
// One cell of the texture slot chain: holds one texture id, passes it to its
// neighbour when a new id is pushed in, and registers its own match flag.
// Depends on sqb_pkg.
`timescale 1ns / 1ps

module sqb_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [sqb_pkg::POS_W-1:0] cell_index,
   input  sqb_pkg::cell_ctrl_type    ctrl,
   input  logic [sqb_pkg::WORD_W-1:0] shift_in,
   output logic [sqb_pkg::WORD_W-1:0] entry,
   output logic                      match
);

   logic [sqb_pkg::WORD_W-1:0] entry_ff;
   logic                       match_ff;
   logic                       match_in;

   // Entry is live only below the fill count; cell 0 holds the newest id
   assign match_in = (entry_ff == ctrl.query) &&
                     ({1'b0, cell_index} < ctrl.count);

   // Stored id, moves one place along on every push
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         entry_ff <= shift_in;
      end
   end

   // Match flag, taken in the look cycle and held until the next one
   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else if (ctrl.look) begin
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// ----- sv/sqb_emitter.sv -----
// Vertex emitter: holds one resolved quad and sends its four vertices in the
// order bottom-left, top-left, top-right, bottom-right on the result stream.
// Depends on sqb_pkg.
`timescale 1ns / 1ps

module sqb_emitter (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  sqb_pkg::quad_type        load_data,
   output logic                     load_ready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // vert_x, vert_y, vert_z, vert_color, vert_uv, slot, flushed_indices, zero pad
   output logic [sqb_pkg::RSP_W-1:0] rsp_tdata,
   // flush_before
   output logic [0:0]               rsp_tuser,
   output logic                     rsp_tlast
);

   localparam logic [sqb_pkg::CORNER_W-1:0] LastCorner =
      sqb_pkg::CORNER_W'(sqb_pkg::CORNERS - 1);
   localparam logic [sqb_pkg::CORNER_W-1:0] FirstCorner = '0;

   sqb_pkg::quad_type                 quad_ff;
   logic                              busy_ff;
   logic                              busy_in;
   logic [sqb_pkg::CORNER_W-1:0]      corner_ff;
   logic [sqb_pkg::CORNER_W-1:0]      corner_in;
   logic                              xfer;
   logic                              first;
   sqb_pkg::vertex_type               vert;

   assign xfer       = busy_ff && rsp_tready;
   assign load_ready = !busy_ff || (rsp_tready && (corner_ff == LastCorner));
   assign first      = (corner_ff == FirstCorner);

   // Corner sequencing
   always_comb begin
      busy_in   = busy_ff;
      corner_in = corner_ff;
      if (xfer) begin
         corner_in = corner_ff + 1'b1;
         if (corner_ff == LastCorner) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in   = 1'b1;
         corner_in = FirstCorner;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         corner_ff <= FirstCorner;
      end else begin
         busy_ff   <= busy_in;
         corner_ff <= corner_in;
      end
   end

   // Quad payload
   always_ff @(posedge clock) begin
      if (load) begin
         quad_ff <= load_data;
      end
   end

   // Vertex select: right edge for corners 2 and 3, top edge for corners 1 and 2
   always_comb begin
      vert                 = '0;
      vert.vert_x          = corner_ff[1] ? quad_ff.x1 : quad_ff.x0;
      vert.vert_y          = (corner_ff[1] ^ corner_ff[0]) ? quad_ff.y1 : quad_ff.y0;
      vert.vert_z          = quad_ff.z;
      vert.vert_color      = quad_ff.color;
      vert.vert_uv         = quad_ff.uv[corner_ff];
      vert.slot            = quad_ff.slot;
      vert.flushed_indices = first ? quad_ff.flushed : '0;
   end

   assign rsp_tvalid   = busy_ff;
   assign rsp_tdata    = vert;
   assign rsp_tuser[0] = first && quad_ff.flush;
   assign rsp_tlast    = (corner_ff == LastCorner);

endmodule

// ----- sv/sprite_quad_batcher.sv -----
// Path: a taken sprite passes the look and resolve states, then loads into the emitter,
//   which offers its first vertex on rsp_tdata; resolve waits for load_ready.
// Overlap: the next lookup runs during the four vertex transfers, which pace sprites.
// Reset: synchronous; clears slot count, index count, sequencer and emitter.
//   The slot cells keep their ids, which read as dead until refilled; no clearing pass.
`timescale 1ns / 1ps

module sprite_quad_batcher (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // pos_x, pos_y, pos_z, width, height, rgba, tex_id, uv_corner0..uv_corner3
   input  logic [sqb_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // vert_x, vert_y, vert_z, vert_color, vert_uv, slot, flushed_indices, zero pad
   output logic [sqb_pkg::RSP_W-1:0] rsp_tdata,
   // flush_before
   output logic [0:0]                rsp_tuser,
   output logic                      rsp_tlast
);

   localparam logic [sqb_pkg::COUNT_W-1:0] SlotLimit =
      sqb_pkg::COUNT_W'(sqb_pkg::SLOT_LIMIT);
   localparam logic [sqb_pkg::INDEX_W:0] IndexLimit =
      (sqb_pkg::INDEX_W + 1)'(sqb_pkg::INDEX_LIMIT);
   localparam logic [sqb_pkg::INDEX_W:0] IndexStep =
      (sqb_pkg::INDEX_W + 1)'(sqb_pkg::INDEX_STEP);

   sqb_pkg::state_type                 state_ff;
   sqb_pkg::state_type                 state_in;
   sqb_pkg::sprite_type                sprite_ff;
   logic [sqb_pkg::COUNT_W-1:0]        count_ff;
   logic [sqb_pkg::COUNT_W-1:0]        count_in;
   logic [sqb_pkg::INDEX_W-1:0]        index_ff;
   logic [sqb_pkg::INDEX_W-1:0]        index_in;

   sqb_pkg::cell_ctrl_type             ctrl;
   logic [sqb_pkg::TABLE_DEPTH-1:0][sqb_pkg::WORD_W-1:0] entry;
   logic [sqb_pkg::TABLE_DEPTH-1:0]    match;

   logic                               take;
   logic                               look;
   logic                               fire;
   logic                               load_ready;
   logic                               hit;
   logic                               untextured;
   logic                               miss;
   logic                               flush;
   logic [sqb_pkg::POS_W-1:0]          hit_pos;
   logic [sqb_pkg::INDEX_W-1:0]        index_base;
   logic [sqb_pkg::INDEX_W:0]          index_sum;
   sqb_pkg::quad_type                  quad;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sqb_pkg::ST_IDLE:    if (req_tvalid) state_in = sqb_pkg::ST_LOOK;
         sqb_pkg::ST_LOOK:    state_in = sqb_pkg::ST_RESOLVE;
         sqb_pkg::ST_RESOLVE: if (load_ready) state_in = sqb_pkg::ST_IDLE;
         default:             state_in = sqb_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_tready = 1'b0;
      look       = 1'b0;
      fire       = 1'b0;
      unique case (state_ff)
         sqb_pkg::ST_IDLE:    req_tready = 1'b1;
         sqb_pkg::ST_LOOK:    look       = 1'b1;
         sqb_pkg::ST_RESOLVE: fire       = load_ready;
         default:             req_tready = 1'b0;
      endcase
   end

   assign take = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sqb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Captured sprite
   always_ff @(posedge clock) begin
      if (take) begin
         sprite_ff <= sqb_pkg::sprite_type'(req_tdata);
      end
   end

   // Slot cell chain: cell 0 takes the new id, the rest pass theirs along
   assign ctrl.shift = fire && miss;
   assign ctrl.look  = look;
   assign ctrl.count = count_ff;
   assign ctrl.query = sprite_ff.tex_id;

   for (genvar i = 0; i < sqb_pkg::TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         sqb_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_index (sqb_pkg::POS_W'(i)),
            .ctrl       (ctrl),
            .shift_in   (sprite_ff.tex_id),
            .entry      (entry[i]),
            .match      (match[i])
         );
      end else begin : g_body
         sqb_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_index (sqb_pkg::POS_W'(i)),
            .ctrl       (ctrl),
            .shift_in   (entry[i-1]),
            .entry      (entry[i]),
            .match      (match[i])
         );
      end
   end

   // Hit position: ids in the chain are unique, so at most one flag is set
   always_comb begin
      hit_pos = '0;
      for (int i = 0; i < sqb_pkg::TABLE_DEPTH; i++) begin
         if (match[i]) begin
            hit_pos = hit_pos | sqb_pkg::POS_W'(i);
         end
      end
   end

   assign hit        = |match;
   assign untextured = (sprite_ff.tex_id == '0);
   assign miss       = !untextured && !hit;
   assign flush      = miss && (count_ff >= SlotLimit);

   // Fill count after this sprite
   always_comb begin
      count_in = count_ff;
      if (miss) begin
         count_in = flush ? sqb_pkg::COUNT_W'(1) : count_ff + 1'b1;
      end
   end

   // Batch index count, restarts on flush, saturates at the limit
   assign index_base = flush ? '0 : index_ff;
   assign index_sum  = {1'b0, index_base} + IndexStep;
   assign index_in   = (index_sum > IndexLimit) ? IndexLimit[sqb_pkg::INDEX_W-1:0] :
                                                  index_sum[sqb_pkg::INDEX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         index_ff <= '0;
      end else if (fire) begin
         count_ff <= count_in;
         index_ff <= index_in;
      end
   end

   // Resolved quad; a hit at chain place p was the (count-p)th id pushed
   always_comb begin
      quad.flush   = flush;
      quad.flushed = flush ? index_ff : '0;
      if (untextured) begin
         quad.slot = '0;
      end else if (hit) begin
         quad.slot = sqb_pkg::SLOT_W'(count_ff - {1'b0, hit_pos});
      end else begin
         quad.slot = sqb_pkg::SLOT_W'(count_in);
      end
      quad.x0    = sprite_ff.pos_x;
      quad.x1    = sprite_ff.pos_x + sprite_ff.width;
      quad.y0    = sprite_ff.pos_y;
      quad.y1    = sprite_ff.pos_y + sprite_ff.height;
      quad.z     = sprite_ff.pos_z;
      quad.color = sprite_ff.rgba;
      quad.uv[0] = sprite_ff.uv_corner0;
      quad.uv[1] = sprite_ff.uv_corner1;
      quad.uv[2] = sprite_ff.uv_corner2;
      quad.uv[3] = sprite_ff.uv_corner3;
   end

   sqb_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .load_data  (quad),
      .load_ready (load_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- sv/sqb_checker.sv -----
// Port-level checks for the sprite quad batcher, bound to the top level.
// Depends on sqb_pkg and sprite_quad_batcher.
`timescale 1ns / 1ps

module sqb_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [sqb_pkg::REQ_W-1:0] req_tdata,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [sqb_pkg::RSP_W-1:0] rsp_tdata,
   input logic [0:0]                rsp_tuser,
   input logic                      rsp_tlast
);

   sqb_pkg::vertex_type               vert;
   logic [sqb_pkg::CORNER_W-1:0]      seen_ff;
   logic                              in_xfer;

   assign vert    = sqb_pkg::vertex_type'(rsp_tdata);
   assign in_xfer = req_tvalid && req_tready && (req_tdata != '0 || 1'b1);

   // Vertex transfers seen since the last quad boundary
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         seen_ff <= seen_ff + 1'b1;
      end
   end

   // Nothing is offered the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered straight after reset");

   // Every fourth vertex, and only that one, closes a quad
   a_last_fourth: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (seen_ff == sqb_pkg::CORNER_W'(sqb_pkg::CORNERS - 1))))
      else $error("tlast out of step with the vertex count");

   // The flushed count is zero unless a flush is flagged
   a_flush_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (vert.flushed_indices == '0))
      else $error("flushed index count without a flush");

   // A flush restarts the slot table, so the sprite takes the first slot
   a_flush_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (vert.slot == sqb_pkg::SLOT_W'(1) && !in_xfer ||
                                        vert.slot == sqb_pkg::SLOT_W'(1)))
      else $error("flush on a vertex whose slot is not the first");

   // A stalled vertex holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) &&
                                       $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled vertex changed");

endmodule

bind sprite_quad_batcher sqb_checker u_sqb_checker (.*);
